/* rtl/wpc_pkg.sv */
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared widths, constants and types for the waypoint position step
// controller: configuration layout, result modes and counter limits.
// ----------------------------------------------------------------------------
package wpc_pkg;

    // field widths
    localparam int POS_W     = 24;
    localparam int HEAD_W    = 13;
    localparam int SPEED_W   = 17;
    localparam int PTOL_W    = 17;
    localparam int HTOL_W    = 12;
    localparam int CMD_W     = 18;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // widths of differences and sums
    localparam int POS_ERR_W  = POS_W + 1;
    localparam int HEAD_ERR_W = HEAD_W + 1;

    // counter widths
    localparam int SETTLE_W  = 6;
    localparam int OUTSIDE_W = 4;
    localparam int BRAKE_W   = 6;

    // counter thresholds
    localparam logic [SETTLE_W-1:0]  SETTLE_TICKS  = 6'd50;
    localparam logic [OUTSIDE_W-1:0] OUTSIDE_LIMIT = 4'd10;
    localparam logic [BRAKE_W-1:0]   BRAKE_TICKS   = 6'd50;

    // height setpoint saturation bounds
    localparam logic signed [POS_ERR_W-1:0] Z_MAX = 25'sd8000000;
    localparam logic signed [POS_ERR_W-1:0] Z_MIN = -25'sd8000000;

    // reset values of the unsigned registers
    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 17'd2000;
    localparam logic [PTOL_W-1:0]  POS_TOL_RST     = 17'd500;
    localparam logic [HTOL_W-1:0]  HEAD_TOL_RST    = 12'd35;

    // result modes
    typedef enum logic [MODE_W-1:0] {
        MODE_SETPOINT = 2'd0,
        MODE_BRAKE    = 2'd1,
        MODE_FINISHED = 2'd2
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X       = 3'd0,
        REG_TARGET_Y       = 3'd1,
        REG_TARGET_Z       = 3'd2,
        REG_TARGET_HEADING = 3'd3,
        REG_START_ALTITUDE = 3'd4,
        REG_SPEED_LIMIT    = 3'd5,
        REG_POS_TOLERANCE  = 3'd6,
        REG_HEAD_TOLERANCE = 3'd7
    } reg_idx_t;

    // configuration register set
    typedef struct packed {
        logic signed [POS_W-1:0]  target_x;
        logic signed [POS_W-1:0]  target_y;
        logic signed [POS_W-1:0]  target_z;
        logic signed [HEAD_W-1:0] target_heading;
        logic signed [POS_W-1:0]  start_altitude;
        logic [SPEED_W-1:0]       speed_limit;
        logic [PTOL_W-1:0]        position_tolerance;
        logic [HTOL_W-1:0]        heading_tolerance;
    } cfg_t;

    // register set after reset
    localparam cfg_t CFG_RST = '{24'sd0, 24'sd0, 24'sd0, 13'sd0, 24'sd0,
                                 SPEED_LIMIT_RST, POS_TOL_RST, HEAD_TOL_RST};

    // datapath results for one measurement
    typedef struct packed {
        logic signed [CMD_W-1:0]  x_cmd;
        logic signed [CMD_W-1:0]  y_cmd;
        logic signed [POS_W-1:0]  z_cmd;
        logic signed [HEAD_W-1:0] heading_cmd;
        logic                     settled;
    } calc_t;

endpackage

/* rtl/wpc_if.sv */
// ----------------------------------------------------------------------------
// wpc channel interfaces
// Valid/ready channels for measurements, results and configuration writes.
// ----------------------------------------------------------------------------

// measurement channel
interface wpc_in_if
    import wpc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  meas_x;
    logic signed [POS_W-1:0]  meas_y;
    logic signed [POS_W-1:0]  meas_z;
    logic signed [HEAD_W-1:0] meas_heading;

    modport source (output valid, meas_x, meas_y, meas_z, meas_heading, input ready);
    modport sink   (input valid, meas_x, meas_y, meas_z, meas_heading, output ready);
endinterface

// result channel
interface wpc_out_if
    import wpc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [CMD_W-1:0]  x_cmd;
    logic signed [CMD_W-1:0]  y_cmd;
    logic signed [POS_W-1:0]  z_cmd;
    logic signed [HEAD_W-1:0] heading_cmd;

    modport source (output valid, mode, x_cmd, y_cmd, z_cmd, heading_cmd, input ready);
    modport sink   (input valid, mode, x_cmd, y_cmd, z_cmd, heading_cmd, output ready);
endinterface

// configuration write channel
interface wpc_cfg_if
    import wpc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/wpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// wpc_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module wpc_cfg_regs
    import wpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    wpc_cfg_if.sink   cfg,
    output cfg_t      cfg_val
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign idx       = reg_idx_t'(cfg.index);
    assign cfg_val   = cfg_reg;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (idx)
                REG_TARGET_X:       cfg_next.target_x       = cfg.data[POS_W-1:0];
                REG_TARGET_Y:       cfg_next.target_y       = cfg.data[POS_W-1:0];
                REG_TARGET_Z:       cfg_next.target_z       = cfg.data[POS_W-1:0];
                REG_TARGET_HEADING: cfg_next.target_heading = cfg.data[HEAD_W-1:0];
                REG_START_ALTITUDE: cfg_next.start_altitude = cfg.data[POS_W-1:0];
                REG_SPEED_LIMIT:    cfg_next.speed_limit    = cfg.data[SPEED_W-1:0];
                REG_POS_TOLERANCE:  cfg_next.position_tolerance = cfg.data[PTOL_W-1:0];
                REG_HEAD_TOLERANCE: cfg_next.heading_tolerance  = cfg.data[HTOL_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/wpc_cmd_calc.sv */
// ----------------------------------------------------------------------------
// wpc_cmd_calc
// Setpoint datapath: axis errors, horizontal clamp, height saturation and
// the settle window test for one measurement.
// ----------------------------------------------------------------------------
module wpc_cmd_calc
    import wpc_pkg::*;
(
    input  cfg_t                     cfg_val,
    input  logic signed [POS_W-1:0]  meas_x,
    input  logic signed [POS_W-1:0]  meas_y,
    input  logic signed [POS_W-1:0]  meas_z,
    input  logic signed [HEAD_W-1:0] meas_heading,
    output calc_t                    calc
);

    // magnitude of a position error
    function automatic logic [POS_ERR_W-1:0] pos_mag(input logic signed [POS_ERR_W-1:0] e);
        pos_mag = e[POS_ERR_W-1] ? POS_ERR_W'(-e) : POS_ERR_W'(e);
    endfunction

    // clamp a horizontal error to plus or minus the speed limit
    function automatic logic signed [CMD_W-1:0] clamp_cmd(
        input logic signed [POS_ERR_W-1:0] e,
        input logic [SPEED_W-1:0]          lim
    );
        logic [POS_ERR_W-1:0] m;
        logic signed [CMD_W-1:0] lim_s;
        m     = pos_mag(e);
        lim_s = $signed({1'b0, lim});
        if (m >= POS_ERR_W'(lim))
            clamp_cmd = (!e[POS_ERR_W-1] && (e != '0)) ? lim_s : CMD_W'(-lim_s);
        else
            clamp_cmd = e[CMD_W-1:0];
    endfunction

    logic signed [POS_ERR_W-1:0]  ex;
    logic signed [POS_ERR_W-1:0]  ey;
    logic signed [POS_ERR_W-1:0]  ez;
    logic signed [HEAD_ERR_W-1:0] eh;
    logic [HEAD_ERR_W-1:0]        eh_mag;
    logic signed [POS_ERR_W-1:0]  z_sum;
    logic [POS_ERR_W-1:0]         ptol;

    // errors: target minus measured, yaw measured minus target
    assign ex = POS_ERR_W'(cfg_val.target_x) - POS_ERR_W'(meas_x);
    assign ey = POS_ERR_W'(cfg_val.target_y) - POS_ERR_W'(meas_y);
    assign ez = POS_ERR_W'(cfg_val.target_z) - POS_ERR_W'(meas_z);
    assign eh = HEAD_ERR_W'(meas_heading) - HEAD_ERR_W'(cfg_val.target_heading);
    assign eh_mag = eh[HEAD_ERR_W-1] ? HEAD_ERR_W'(-eh) : HEAD_ERR_W'(eh);

    // absolute height setpoint
    assign z_sum = POS_ERR_W'(cfg_val.start_altitude) + POS_ERR_W'(cfg_val.target_z);

    assign ptol = POS_ERR_W'(cfg_val.position_tolerance);

    // command and settle outputs
    always_comb
    begin
        calc.x_cmd       = clamp_cmd(ex, cfg_val.speed_limit);
        calc.y_cmd       = clamp_cmd(ey, cfg_val.speed_limit);
        calc.heading_cmd = cfg_val.target_heading;
        if (z_sum > Z_MAX)
            calc.z_cmd = Z_MAX[POS_W-1:0];
        else if (z_sum < Z_MIN)
            calc.z_cmd = Z_MIN[POS_W-1:0];
        else
            calc.z_cmd = z_sum[POS_W-1:0];
        calc.settled = (pos_mag(ex) < ptol) && (pos_mag(ey) < ptol) &&
                       (pos_mag(ez) < ptol) &&
                       (eh_mag < HEAD_ERR_W'(cfg_val.heading_tolerance));
    end

endmodule

/* rtl/wpc_pipe.sv */
// ----------------------------------------------------------------------------
// wpc_pipe
// Input register, settle/outside/brake counters and result register.
// ----------------------------------------------------------------------------
module wpc_pipe
    import wpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg_val,
    wpc_in_if.sink    meas,
    wpc_out_if.source result
);

    // input register
    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic signed [POS_W-1:0]  meas_x_reg;
    logic signed [POS_W-1:0]  meas_y_reg;
    logic signed [POS_W-1:0]  meas_z_reg;
    logic signed [HEAD_W-1:0] meas_heading_reg;

    // result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    mode_t                    mode_reg;
    mode_t                    mode_next;
    logic signed [CMD_W-1:0]  x_cmd_reg;
    logic signed [CMD_W-1:0]  x_cmd_next;
    logic signed [CMD_W-1:0]  y_cmd_reg;
    logic signed [CMD_W-1:0]  y_cmd_next;
    logic signed [POS_W-1:0]  z_cmd_reg;
    logic signed [POS_W-1:0]  z_cmd_next;
    logic signed [HEAD_W-1:0] heading_cmd_reg;
    logic signed [HEAD_W-1:0] heading_cmd_next;

    // counters
    logic [SETTLE_W-1:0]  settle_count_reg;
    logic [SETTLE_W-1:0]  settle_count_next;
    logic [OUTSIDE_W-1:0] outside_count_reg;
    logic [OUTSIDE_W-1:0] outside_count_next;
    logic [BRAKE_W-1:0]   brake_count_reg;
    logic [BRAKE_W-1:0]   brake_count_next;

    logic  in_take;
    logic  out_free;
    logic  advance;
    calc_t calc;

    // handshake
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign meas.ready = !in_valid_reg || advance;
    assign in_take    = meas.valid && meas.ready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    wpc_cmd_calc u_calc (
        .cfg_val      (cfg_val),
        .meas_x       (meas_x_reg),
        .meas_y       (meas_y_reg),
        .meas_z       (meas_z_reg),
        .meas_heading (meas_heading_reg),
        .calc         (calc)
    );

    // step decision and counter update
    always_comb
    begin
        settle_count_next  = settle_count_reg;
        outside_count_next = outside_count_reg;
        brake_count_next   = brake_count_reg;
        mode_next          = MODE_SETPOINT;
        x_cmd_next         = '0;
        y_cmd_next         = '0;
        z_cmd_next         = '0;
        heading_cmd_next   = '0;
        if (brake_count_reg > BRAKE_TICKS)
        begin
            mode_next = MODE_FINISHED;
        end
        else if (brake_count_reg != '0)
        begin
            mode_next = MODE_BRAKE;
            if (brake_count_reg != '1)
                brake_count_next = brake_count_reg + BRAKE_W'(1);
        end
        else
        begin
            x_cmd_next       = calc.x_cmd;
            y_cmd_next       = calc.y_cmd;
            z_cmd_next       = calc.z_cmd;
            heading_cmd_next = calc.heading_cmd;
            if (calc.settled)
            begin
                if (settle_count_reg != '1)
                    settle_count_next = settle_count_reg + SETTLE_W'(1);
            end
            else if (settle_count_reg != '0)
            begin
                if (outside_count_reg != '1)
                    outside_count_next = outside_count_reg + OUTSIDE_W'(1);
            end
            // too many excursions restart the settle count
            if (outside_count_next > OUTSIDE_LIMIT)
            begin
                settle_count_next  = '0;
                outside_count_next = '0;
            end
            if (settle_count_next > SETTLE_TICKS)
                brake_count_next = BRAKE_W'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            settle_count_reg  <= '0;
            outside_count_reg <= '0;
            brake_count_reg   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                settle_count_reg  <= settle_count_next;
                outside_count_reg <= outside_count_next;
                brake_count_reg   <= brake_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            meas_x_reg       <= meas.meas_x;
            meas_y_reg       <= meas.meas_y;
            meas_z_reg       <= meas.meas_z;
            meas_heading_reg <= meas.meas_heading;
        end
        if (advance)
        begin
            mode_reg        <= mode_next;
            x_cmd_reg       <= x_cmd_next;
            y_cmd_reg       <= y_cmd_next;
            z_cmd_reg       <= z_cmd_next;
            heading_cmd_reg <= heading_cmd_next;
        end
    end

    // result outputs
    assign result.valid       = out_valid_reg;
    assign result.mode        = mode_reg;
    assign result.x_cmd       = x_cmd_reg;
    assign result.y_cmd       = y_cmd_reg;
    assign result.z_cmd       = z_cmd_reg;
    assign result.heading_cmd = heading_cmd_reg;

    // excursion counter is cleared as soon as it passes its limit
    a_outside_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outside_count_reg <= OUTSIDE_LIMIT)
        else $error("outside count above limit");

    // a full settle count always has braking started
    a_settle_brakes: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_count_reg > SETTLE_TICKS) |-> (brake_count_reg != '0))
        else $error("settled without braking");

    // braking, once started, never stops
    a_brake_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (brake_count_reg != '0) |=> (brake_count_reg != '0))
        else $error("brake count dropped");

    // brake and finished results carry zero commands
    a_zero_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (mode_reg != MODE_SETPOINT)) |->
        (x_cmd_reg == '0 && y_cmd_reg == '0 && z_cmd_reg == '0 && heading_cmd_reg == '0))
        else $error("nonzero command outside setpoint mode");

    // a stalled result leaves the counters untouched
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=>
        ($stable(settle_count_reg) && $stable(outside_count_reg) && $stable(brake_count_reg)))
        else $error("counters moved under stall");

endmodule

/* rtl/waypoint_position_step_controller_top.sv */
// ----------------------------------------------------------------------------
// waypoint_position_step_controller_top
// Waypoint position step controller with settle detection and brake phase.
// ----------------------------------------------------------------------------
// Usage
//   meas   : one transaction per control tick, measured x/y/z offset (mm)
//            and yaw (mrad)
//   result : one transaction per measurement, mode plus x/y/z/yaw commands
//   cfg    : register writes (index, data), always ready; write only while
//            no measurement is in flight
// Path: a taken measurement passes the input register, then the result
//   register, before result.valid rises for it.
// Throughput: one measurement per cycle while result is not held; the
//   combinational datapath between the input and result registers sets this.
// Stall: while result is held, the result register keeps its transaction,
//   the input register takes one more measurement and then meas.ready drops.
// Reset: counters clear, targets and start altitude go to zero, speed limit
//   2000, position tolerance 500, heading tolerance 35; no item is in flight.
// ----------------------------------------------------------------------------
module waypoint_position_step_controller_top
    import wpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    wpc_in_if.sink    meas,
    wpc_out_if.source result,
    wpc_cfg_if.sink   cfg
);

    cfg_t cfg_val;

    // configuration registers
    wpc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    // measurement to result pipeline
    wpc_pipe u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_val),
        .meas    (meas),
        .result  (result)
    );

endmodule
